// ----- src/pcsq_pkg.sv -----
// Package for the per-channel symmetric quantizer: payload structs and constants.
// No dependencies.
`default_nettype none
package pcsq_pkg;
  localparam int DEPTH_DEFAULT = 64;
  localparam logic [6:0] CLAMP_RESET = 7'd127;
  localparam logic [30:0] SCALE_MAX = 31'h7FFF_FFFF;
  localparam logic [0:0] REG_CLAMP = 1'b0;

  typedef struct packed {
    logic signed [31:0] weight_sample;
    logic               last_in_channel;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0] quant_value;
    logic [5:0]        element_index;
    logic [30:0]       channel_scale;
    logic              last_out;
    logic              truncated;
  } out_item_t;

  // Divider request/response between sequencer and divider.
  typedef struct packed {
    logic        start;
    logic [39:0] num;
    logic [39:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [39:0] quo;
  } div_rsp_t;
endpackage
`default_nettype wire

// ----- src/pcsq_div.sv -----
// Radix-2 restoring divider, 40-bit unsigned, one quotient bit per cycle.
// Depends on pcsq_pkg.
`default_nettype none
module pcsq_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pcsq_pkg::div_req_t req,
  output pcsq_pkg::div_rsp_t      rsp
);
  import pcsq_pkg::*;

  logic [39:0] quo_r, quo_nxt;
  logic [40:0] rem_r, rem_nxt;
  logic [39:0] den_r, den_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [40:0] trial;

  // Shift in one numerator bit, subtract if it fits
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[39:0], quo_r[39]};
    if (req.start) begin
      quo_nxt  = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
      cnt_nxt  = 6'd40;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        quo_nxt = {quo_r[38:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[38:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

  // Done pulses only after a running division
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("done without busy");
  a_cnt_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r && !req.start |=> cnt_r == $past(cnt_r)) else $error("count moved");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("done while busy");
endmodule
`default_nettype wire

// ----- src/pcsq_buf.sv -----
// Weight buffer: single-port-write, registered-read synchronous memory.
// Depends on pcsq_pkg.
`default_nettype none
module pcsq_buf #(
  parameter int DEPTH = pcsq_pkg::DEPTH_DEFAULT,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [31:0]   wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic [31:0]        rd_data
);
  import pcsq_pkg::*;

  logic [31:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

// ----- src/per_channel_symmetric_quantizer_top.sv -----
// Per-channel symmetric quantizer top: sequencer, APB register, output stage.
// Depends on pcsq_pkg, pcsq_buf, pcsq_div.
//
// Usage: weights enter on in_* one beat per cycle while the block collects a
// channel (Q15.16 signed words). The beat with last_in_channel set, or the
// one that fills the DEPTH-entry buffer, closes the channel (truncated set in
// the latter case). The block then divides once for the scale (on the
// shared bit-serial divider) and, per element, reads the buffer and runs
// one division for the quantized value; the divider sets the rate. Input
// stall stays high from channel close until the last result beat is loaded
// into the output register. Results leave through that register: when
// out_stall is high the beat holds and the sequencer waits.
// clamp_limit is written over the cfg_ APB port at address 0 (reset 127) and
// is used from channel close through the last result of that channel.
// Synchronous active-low reset empties the buffer count and clears max.
`default_nettype none
module per_channel_symmetric_quantizer_top #(
  parameter int DEPTH = pcsq_pkg::DEPTH_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire pcsq_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output pcsq_pkg::out_item_t      out_data,
  input  wire logic                cfg_psel,
  input  wire logic                cfg_penable,
  input  wire logic                cfg_pwrite,
  input  wire logic [2:0]          cfg_paddr,
  input  wire logic [31:0]         cfg_pwdata,
  output logic [31:0]              cfg_prdata,
  output logic                     cfg_pready
);
  import pcsq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  typedef enum logic [5:0] {
    S_FILL  = 6'b000001,
    S_SCALE = 6'b000010,
    S_READ  = 6'b000100,
    S_QDIV  = 6'b001000,
    S_WAIT  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [6:0]    clamp_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [31:0]   amax_r, amax_nxt;
  logic [30:0]   scale_r, scale_nxt;
  logic          trunc_r, trunc_nxt;
  logic          neg_r, neg_nxt;
  logic          out_valid_r;
  out_item_t     out_r, out_nxt;
  logic          out_load;
  div_req_t      dreq;
  div_rsp_t      drsp;
  logic [31:0]   rd_data, mag_in, mag_rd;
  logic [38:0]   qprod;
  logic          in_acc;
  logic [39:0]   q_calc;
  logic [7:0]    q_mag;

  // APB register
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_CLAMP) ? {25'd0, clamp_r} : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) clamp_r <= CLAMP_RESET;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == REG_CLAMP)
      clamp_r <= cfg_pwdata[6:0];
  end

  assign in_stall = (state_r != S_FILL);
  assign in_acc   = in_valid && !in_stall;
  assign mag_in   = in_data.weight_sample[31] ? 32'(-in_data.weight_sample)
                                              : in_data.weight_sample;
  assign mag_rd   = rd_data[31] ? (32'd0 - rd_data) : rd_data;
  // Magnitude times clamp needs 39 bits
  assign qprod    = 39'(mag_rd) * 39'(clamp_r);

  pcsq_buf #(.DEPTH(DEPTH)) u_buf (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (cnt_r[AW-1:0]),
    .wr_data (in_data.weight_sample),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (rd_data)
  );

  pcsq_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // Clamp the division result to clamp_limit
  assign q_calc = (drsp.quo > {33'd0, clamp_r}) ? {33'd0, clamp_r} : drsp.quo;
  assign q_mag  = {1'b0, q_calc[6:0]};

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    amax_nxt  = amax_r;
    scale_nxt = scale_r;
    trunc_nxt = trunc_r;
    neg_nxt   = neg_r;
    out_nxt   = out_r;
    out_load  = 1'b0;
    dreq      = '0;
    unique case (state_r)
      S_FILL: begin
        if (in_acc) begin
          cnt_nxt = cnt_r + CW'(1);
          if (mag_in > amax_r) amax_nxt = mag_in;
          if (in_data.last_in_channel || cnt_r + CW'(1) == DEPTH_C) begin
            trunc_nxt = !in_data.last_in_channel;
            idx_nxt   = '0;
            state_nxt = S_SCALE;
            dreq.start = 1'b1;
            dreq.num   = {7'd0, amax_nxt, 1'b0} + 40'(clamp_r);
            dreq.den   = {32'd0, clamp_r, 1'b0};
          end
        end
      end
      S_SCALE: begin
        if (drsp.done) begin
          if (amax_r == 32'd0) scale_nxt = '0;
          else if (clamp_r == 7'd0 || drsp.quo > {9'd0, SCALE_MAX}) scale_nxt = SCALE_MAX;
          else scale_nxt = drsp.quo[30:0];
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_QDIV;
      S_QDIV: begin
        neg_nxt    = rd_data[31];
        dreq.start = 1'b1;
        dreq.num   = {qprod, 1'b0} + 40'(amax_r);
        dreq.den   = {7'd0, amax_r, 1'b0};
        state_nxt  = S_WAIT;
      end
      S_WAIT: begin
        if (drsp.done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_load = 1'b1;
          out_nxt.quant_value = (amax_r == 0 || clamp_r == 0) ? 8'sd0 :
                                (neg_r ? 8'(-q_mag) : q_mag);
          out_nxt.element_index = 6'(idx_r);
          out_nxt.channel_scale = scale_r;
          out_nxt.last_out      = (idx_r + CW'(1) == cnt_r);
          out_nxt.truncated     = trunc_r;
          idx_nxt = idx_r + CW'(1);
          if (idx_r + CW'(1) == cnt_r) begin
            cnt_nxt   = '0;
            amax_nxt  = '0;
            state_nxt = S_FILL;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      default: state_nxt = S_FILL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      cnt_r       <= '0;
      amax_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      amax_r  <= amax_nxt;
      idx_r   <= idx_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
    scale_r <= scale_nxt;
    trunc_r <= trunc_nxt;
    neg_r   <= neg_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Buffer never overfills; input closed outside fill; last beat ends channel
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C) else $error("fill count overflow");
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_FILL |-> in_stall) else $error("input open while busy");
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && out_nxt.last_out |=> cnt_r == '0 && amax_r == '0)
    else $error("channel state not cleared");
endmodule
`default_nettype wire
